/* rtl/atrlp_pkg.sv */
// Package for the ATR level proximity counter: sizes, register indexes,
// the queue record, the back-end state type and small helper functions.
// Depends on nothing; every other file uses it by scoped names.
package atrlp_pkg;

    localparam int MAX_WINDOW   = 64;
    localparam int PRICE_BITS   = 31;
    localparam int ATR_FRAC     = 8;
    localparam int ATR_BITS     = PRICE_BITS + ATR_FRAC;
    localparam int DEV_BITS     = PRICE_BITS + 1;
    localparam int SLOT_BITS    = $clog2(MAX_WINDOW);
    localparam int HELD_BITS    = $clog2(MAX_WINDOW + 1);
    localparam int SUM_BITS     = PRICE_BITS + SLOT_BITS;
    localparam int DVD_BITS     = SUM_BITS + ATR_FRAC;
    localparam int DIV_CNT_BITS = $clog2(DVD_BITS);
    localparam int MULT_BITS    = 16;
    localparam int TOL_FRAC     = 16;
    localparam int MUL_SPLIT    = ATR_BITS / 2;
    localparam int PROD_BITS    = MULT_BITS + ATR_BITS;
    localparam int WIN_BITS     = 7;
    localparam int CFG_IDX_BITS = 8;
    localparam int CFG_DATA_BITS = 16;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_BITS    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_BITS-1:0] CFG_TOL_MULT = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] CFG_WIN_LEN  = CFG_IDX_BITS'(1);

    localparam logic [MULT_BITS-1:0] TOL_MULT_RESET = MULT_BITS'(256);
    localparam int WIN_LEN_DEFAULT = (14 > MAX_WINDOW) ? MAX_WINDOW : 14;
    localparam logic [HELD_BITS-1:0] WIN_LEN_RESET = HELD_BITS'(WIN_LEN_DEFAULT);

    // One bar after classification, as it waits for the back end.
    typedef struct packed {
        logic [PRICE_BITS-1:0] tr;
        logic [DEV_BITS-1:0]   dev2;
        logic [PRICE_BITS-1:0] cdev;
    } rec_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ,
        BK_UPDATE,
        BK_DIVIDE,
        BK_MUL_LO,
        BK_MUL_HI,
        BK_COMBINE,
        BK_FINISH
    } back_state_t;

    typedef struct packed {
        logic idle;
        logic finishing;
    } back_stat_t;

    function automatic logic [PRICE_BITS-1:0] absdiff(
        input logic [PRICE_BITS-1:0] a,
        input logic [PRICE_BITS-1:0] b
    );
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [PRICE_BITS-1:0] max2(
        input logic [PRICE_BITS-1:0] a,
        input logic [PRICE_BITS-1:0] b
    );
        return (a >= b) ? a : b;
    endfunction

endpackage

/* rtl/atrlp_bar_if.sv */
// Input channel interface: one price bar per request.
// Depends on atrlp_pkg for the price width.
interface atrlp_bar_if;
    logic                             valid;
    logic                             ready;
    logic [atrlp_pkg::PRICE_BITS-1:0] bar_high;
    logic [atrlp_pkg::PRICE_BITS-1:0] bar_low;
    logic [atrlp_pkg::PRICE_BITS-1:0] bar_close;

    modport source (output valid, output bar_high, output bar_low, output bar_close,
                    input ready);
    modport sink (input valid, input bar_high, input bar_low, input bar_close,
                  output ready);
endinterface

/* rtl/atrlp_result_if.sv */
// Result channel interface: proximity count and ATR per request.
// Depends on atrlp_pkg for the ATR width.
interface atrlp_result_if;
    logic                           valid;
    logic                           ready;
    logic [1:0]                     near_count;
    logic [atrlp_pkg::ATR_BITS-1:0] atr_value;

    modport source (output valid, output near_count, output atr_value, input ready);
    modport sink (input valid, input near_count, input atr_value, output ready);
endinterface

/* rtl/atrlp_cfg_if.sv */
// Configuration write channel interface: register index and write data.
// Depends on atrlp_pkg for the field widths.
interface atrlp_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [atrlp_pkg::CFG_IDX_BITS-1:0]  index;
    logic [atrlp_pkg::CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/atr_level_proximity_counter.sv */
// Top level of the ATR level proximity counter: front end, bar queue and
// back end. Depends on atrlp_pkg, the three channel interfaces and the submodules.
//
//   channel  direction  carries                              handshake
//   bar      in         bar_high, bar_low, bar_close         valid/ready
//   result   out        near_count, atr_value                valid/ready
//   cfg      in         index, data (0 multiplier, 1 window) valid/ready, always ready
//
// Each bar in the back end goes through the bit-serial ATR divider, which
// produces one quotient bit per cycle. The back end holds one bar at a time.
// The first bar after reset is only recorded and gives no result.
// Reset clears all control state; the window memory is not cleared, since an
// entry is always written before its value is used.
// The queue holds two classified bars; a finished result waits in the output
// register while the back end stalls, and bars are taken while the queue has room.
module atr_level_proximity_counter (
    input  logic            clk,
    input  logic            rst_n,
    atrlp_bar_if.sink       bar,
    atrlp_result_if.source  result,
    atrlp_cfg_if.sink       cfg
);

    logic                  push_valid;
    logic                  push_ready;
    atrlp_pkg::rec_t       push_rec;
    logic                  q_valid;
    logic                  q_ready;
    atrlp_pkg::rec_t       q_rec;
    atrlp_pkg::back_stat_t stat;

    atrlp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .bar        (bar),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_rec   (push_rec)
    );

    atrlp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_rec   (push_rec),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_rec    (q_rec)
    );

    atrlp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .rec_valid (q_valid),
        .rec_ready (q_ready),
        .rec_in    (q_rec),
        .result    (result),
        .stat      (stat)
    );

`ifndef NO_ASSERTIONS
    // A result appears only out of the final step of the back end.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(stat.finishing))
        else $error("result raised without a finishing step");

    // While the output register is occupied and not taken, the back end waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        stat.finishing && result.valid && !result.ready |=> stat.finishing)
        else $error("back end left its final step while the output was blocked");

    // A waiting queue entry is taken by an idle back end at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_valid && stat.idle |=> !stat.idle)
        else $error("idle back end ignored a queued bar");
`endif

endmodule

/* rtl/atrlp_front.sv */
// Front end: accepts bars, keeps the previous close and classifies each bar
// into true range and scaled deviations. Depends on atrlp_pkg, atrlp_bar_if.
module atrlp_front (
    input  logic             clk,
    input  logic             rst_n,
    atrlp_bar_if.sink        bar,
    output logic             push_valid,
    input  logic             push_ready,
    output atrlp_pkg::rec_t  push_rec
);

    logic                             seen_reg;
    logic [atrlp_pkg::PRICE_BITS-1:0] prior_reg;
    logic                             accept;
    logic [atrlp_pkg::DEV_BITS-1:0]   sum_hl;
    logic [atrlp_pkg::DEV_BITS-1:0]   close2;
    logic [atrlp_pkg::PRICE_BITS-1:0] range_hl;

    assign bar.ready = push_ready;
    assign accept    = bar.valid && bar.ready;
    // The first bar after reset only records its close.
    assign push_valid = bar.valid && seen_reg;

    always_comb
    begin
        sum_hl   = {1'b0, bar.bar_high} + {1'b0, bar.bar_low};
        close2   = {bar.bar_close, 1'b0};
        range_hl = atrlp_pkg::absdiff(bar.bar_high, bar.bar_low);
        push_rec.tr = atrlp_pkg::max2(
            atrlp_pkg::max2(range_hl, atrlp_pkg::absdiff(bar.bar_high, prior_reg)),
            atrlp_pkg::absdiff(bar.bar_low, prior_reg));
        push_rec.dev2 = (close2 >= sum_hl) ? (close2 - sum_hl) : (sum_hl - close2);
        push_rec.cdev = atrlp_pkg::absdiff(bar.bar_close, prior_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg  <= 1'b0;
            prior_reg <= '0;
        end
        else if (accept)
        begin
            seen_reg  <= 1'b1;
            prior_reg <= bar.bar_close;
        end
    end

endmodule

/* rtl/atrlp_queue.sv */
// Short first-in first-out queue of classified bars between the front and
// back ends. Depends on atrlp_pkg for the record type and depth.
module atrlp_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  atrlp_pkg::rec_t  push_rec,
    output logic             pop_valid,
    input  logic             pop_ready,
    output atrlp_pkg::rec_t  pop_rec
);

    atrlp_pkg::rec_t                 slots_reg [atrlp_pkg::QUEUE_DEPTH];
    logic [atrlp_pkg::QPTR_BITS-1:0] wr_ptr_reg;
    logic [atrlp_pkg::QPTR_BITS-1:0] rd_ptr_reg;
    logic [atrlp_pkg::QCNT_BITS-1:0] count_reg;
    logic                            do_push;
    logic                            do_pop;

    localparam logic [atrlp_pkg::QPTR_BITS-1:0] LAST_PTR =
        atrlp_pkg::QPTR_BITS'(atrlp_pkg::QUEUE_DEPTH - 1);

    assign push_ready = (count_reg != atrlp_pkg::QCNT_BITS'(atrlp_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_rec    = slots_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/atrlp_back.sv */
// Back end: sliding window of true ranges, bit-serial ATR divider, tolerance
// multiply, level compares and the result register. Also holds the
// configuration registers. Depends on atrlp_pkg, atrlp_cfg_if, atrlp_result_if.
module atrlp_back (
    input  logic                   clk,
    input  logic                   rst_n,
    atrlp_cfg_if.sink              cfg,
    input  logic                   rec_valid,
    output logic                   rec_ready,
    input  atrlp_pkg::rec_t        rec_in,
    atrlp_result_if.source         result,
    output atrlp_pkg::back_stat_t  stat
);

    localparam int PB = atrlp_pkg::PRICE_BITS;
    localparam int HB = atrlp_pkg::HELD_BITS;
    localparam int SB = atrlp_pkg::SLOT_BITS;
    localparam int UB = atrlp_pkg::SUM_BITS;
    localparam int DB = atrlp_pkg::DVD_BITS;
    localparam int AB = atrlp_pkg::ATR_BITS;
    localparam int MB = atrlp_pkg::MULT_BITS;
    localparam int XB = atrlp_pkg::PROD_BITS;
    localparam int LO = atrlp_pkg::MUL_SPLIT;
    localparam int CB = atrlp_pkg::DIV_CNT_BITS;
    localparam logic [CB-1:0] DIV_LAST = CB'(DB - 1);

    atrlp_pkg::back_state_t state_reg;
    atrlp_pkg::back_state_t state_next;

    logic [MB-1:0]  mult_reg;
    logic [HB-1:0]  win_len_reg;
    logic [HB-1:0]  held_reg;
    logic [HB-1:0]  held_next;
    logic [SB-1:0]  slot_reg;
    logic [SB-1:0]  slot_norm;
    logic [SB-1:0]  slot_next;
    logic [HB-1:0]  slot_inc;
    logic [UB-1:0]  sum_reg;
    logic [UB-1:0]  sum_next;
    logic           window_full;

    logic [PB-1:0]  range_window [atrlp_pkg::MAX_WINDOW];
    logic [PB-1:0]  old_reg;

    atrlp_pkg::rec_t rec_reg;
    logic [DB-1:0]  dvd_reg;
    logic [HB-1:0]  rem_reg;
    logic [CB-1:0]  div_cnt_reg;
    logic [HB:0]    trial;
    logic           trial_ge;
    logic [AB-1:0]  atr;

    logic [MB+LO-1:0]      plo_reg;
    logic [MB+AB-LO-1:0]   phi_reg;
    logic [XB-1:0]         prod_reg;
    logic [XB+1:0]         prod2;
    logic [XB+1:0]         prod3;
    logic [XB+1:0]         dev_ext;
    logic [XB+1:0]         cdev_ext;
    logic                  hit_typ;
    logic                  hit_prev;
    logic                  hit_mid;

    logic [1:0]     near_reg;
    logic [AB-1:0]  atr_out_reg;
    logic           out_valid_reg;

    logic           out_free;
    logic           mem_re;
    logic           mem_we;
    logic           div_load;
    logic           div_step;
    logic           out_load;
    logic [atrlp_pkg::WIN_BITS-1:0] win_raw;
    logic [HB-1:0]  win_sat;

    assign out_free = !out_valid_reg || result.ready;
    assign cfg.ready = 1'b1;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            atrlp_pkg::BK_IDLE:    if (rec_valid) state_next = atrlp_pkg::BK_READ;
            atrlp_pkg::BK_READ:    state_next = atrlp_pkg::BK_UPDATE;
            atrlp_pkg::BK_UPDATE:  state_next = atrlp_pkg::BK_DIVIDE;
            atrlp_pkg::BK_DIVIDE:  if (div_cnt_reg == DIV_LAST)
                                       state_next = atrlp_pkg::BK_MUL_LO;
            atrlp_pkg::BK_MUL_LO:  state_next = atrlp_pkg::BK_MUL_HI;
            atrlp_pkg::BK_MUL_HI:  state_next = atrlp_pkg::BK_COMBINE;
            atrlp_pkg::BK_COMBINE: state_next = atrlp_pkg::BK_FINISH;
            atrlp_pkg::BK_FINISH:  if (out_free) state_next = atrlp_pkg::BK_IDLE;
            default:               state_next = atrlp_pkg::BK_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb
    begin
        rec_ready = 1'b0;
        mem_re    = 1'b0;
        mem_we    = 1'b0;
        div_load  = 1'b0;
        div_step  = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            atrlp_pkg::BK_IDLE:   rec_ready = 1'b1;
            atrlp_pkg::BK_READ:   mem_re = 1'b1;
            atrlp_pkg::BK_UPDATE:
            begin
                mem_we   = 1'b1;
                div_load = 1'b1;
            end
            atrlp_pkg::BK_DIVIDE: div_step = 1'b1;
            atrlp_pkg::BK_FINISH: out_load = out_free;
            default:
            begin
                rec_ready = 1'b0;
            end
        endcase
    end

    assign stat.idle      = (state_reg == atrlp_pkg::BK_IDLE);
    assign stat.finishing = (state_reg == atrlp_pkg::BK_FINISH);

    // Window bookkeeping.
    always_comb
    begin
        slot_norm   = (HB'(slot_reg) >= win_len_reg) ? '0 : slot_reg;
        slot_inc    = HB'(slot_reg) + 1'b1;
        slot_next   = (slot_inc >= win_len_reg) ? '0 : SB'(slot_inc);
        window_full = (held_reg >= win_len_reg);
        held_next   = window_full ? held_reg : held_reg + 1'b1;
        if (window_full)
        begin
            sum_next = sum_reg - UB'(old_reg) + UB'(rec_reg.tr);
        end
        else
        begin
            sum_next = sum_reg + UB'(rec_reg.tr);
        end
    end

    // Restoring division, one quotient bit per cycle.
    assign trial    = {rem_reg, dvd_reg[DB-1]};
    assign trial_ge = (trial >= {1'b0, held_reg});
    assign atr      = dvd_reg[AB-1:0];

    // Tolerance compares, all exact: tol_k = floor(k * mult * atr / 2^16).
    always_comb
    begin
        prod2    = {1'b0, prod_reg, 1'b0};
        prod3    = {2'b00, prod_reg} + prod2;
        dev_ext  = (XB + 2)'(rec_reg.dev2);
        cdev_ext = (XB + 2)'(rec_reg.cdev);
        hit_typ  = (dev_ext  <= (prod3 >> atrlp_pkg::TOL_FRAC));
        hit_prev = (cdev_ext <= ({2'b00, prod_reg} >> atrlp_pkg::TOL_FRAC));
        hit_mid  = (dev_ext  <= (prod2 >> atrlp_pkg::TOL_FRAC));
    end

    // Window length write: zero reads as one, large values saturate.
    always_comb
    begin
        win_raw = cfg.data[atrlp_pkg::WIN_BITS-1:0];
        if (win_raw == '0)
        begin
            win_sat = HB'(1);
        end
        else if (int'(win_raw) > atrlp_pkg::MAX_WINDOW)
        begin
            win_sat = HB'(atrlp_pkg::MAX_WINDOW);
        end
        else
        begin
            win_sat = HB'(win_raw);
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            range_window[slot_reg] <= rec_reg.tr;
        end
        if (mem_re)
        begin
            old_reg <= range_window[slot_norm];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= atrlp_pkg::BK_IDLE;
            mult_reg      <= atrlp_pkg::TOL_MULT_RESET;
            win_len_reg   <= atrlp_pkg::WIN_LEN_RESET;
            held_reg      <= '0;
            slot_reg      <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (mem_re)
            begin
                slot_reg <= slot_norm;
            end
            if (mem_we)
            begin
                slot_reg <= slot_next;
                held_reg <= held_next;
                sum_reg  <= sum_next;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            // Writes only while idle, unenforced; a length write empties the window.
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == atrlp_pkg::CFG_TOL_MULT)
                begin
                    mult_reg <= cfg.data[MB-1:0];
                end
                else if (cfg.index == atrlp_pkg::CFG_WIN_LEN)
                begin
                    win_len_reg <= win_sat;
                    held_reg    <= '0;
                    slot_reg    <= '0;
                    sum_reg     <= '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rec_ready && rec_valid)
        begin
            rec_reg <= rec_in;
        end
        if (div_load)
        begin
            dvd_reg     <= {sum_next, atrlp_pkg::ATR_FRAC'(0)};
            rem_reg     <= '0;
            div_cnt_reg <= '0;
        end
        else if (div_step)
        begin
            dvd_reg     <= {dvd_reg[DB-2:0], trial_ge};
            rem_reg     <= trial_ge ? HB'(trial - {1'b0, held_reg}) : HB'(trial);
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
        if (state_reg == atrlp_pkg::BK_MUL_LO)
        begin
            plo_reg <= (MB + LO)'(mult_reg) * (MB + LO)'(atr[LO-1:0]);
        end
        if (state_reg == atrlp_pkg::BK_MUL_HI)
        begin
            phi_reg <= (MB + AB - LO)'(mult_reg) * (MB + AB - LO)'(atr[AB-1:LO]);
        end
        if (state_reg == atrlp_pkg::BK_COMBINE)
        begin
            prod_reg <= XB'(plo_reg) + (XB'(phi_reg) << LO);
        end
        if (out_load)
        begin
            near_reg    <= 2'(hit_typ) + 2'(hit_prev) + 2'(hit_mid);
            atr_out_reg <= atr;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.near_count = near_reg;
    assign result.atr_value  = atr_out_reg;

endmodule
